// ===== src/etfc_pkg.sv =====
package etfc_pkg;

  // Sample and counter widths
  localparam int SAMPLE_BITS   = 12;
  localparam int CNT_BITS      = 20;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELD_BITS  = 4 * SAMPLE_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = CNT_BITS + 4 * SAMPLE_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] RST_TRIGGER_LEVEL = SAMPLE_BITS'(2048);
  localparam logic [CNT_BITS-1:0]    RST_AUTO_TIMEOUT  = CNT_BITS'(5000);
  localparam logic [CNT_BITS-1:0]    RST_FRAME_LENGTH  = CNT_BITS'(1000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIGGER_LEVEL = 3'd0,
    REG_RISING_EDGE   = 3'd1,
    REG_AUTO_MODE     = 3'd2,
    REG_AUTO_TIMEOUT  = 3'd3,
    REG_FRAME_LENGTH  = 3'd4,
    REG_DUAL_CHANNEL  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] trigger_level;
    logic                   rising_edge;
    logic                   auto_mode;
    logic [CNT_BITS-1:0]    auto_timeout_samples;
    logic [CNT_BITS-1:0]    frame_length;
    logic                   dual_channel;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ch1_raw;
    logic [SAMPLE_BITS-1:0] ch1_filtered;
    logic [SAMPLE_BITS-1:0] ch2_raw;
    logic [SAMPLE_BITS-1:0] ch2_filtered;
    logic                   ch2_present;
  } sample_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]    sample_index;
    logic [SAMPLE_BITS-1:0] out_ch1_raw;
    logic [SAMPLE_BITS-1:0] out_ch1_filtered;
    logic [SAMPLE_BITS-1:0] out_ch2_raw;
    logic [SAMPLE_BITS-1:0] out_ch2_filtered;
    logic                   out_ch2_valid;
    logic                   frame_last;
  } result_t;

  // Handshake between the trigger stage and the output register
  typedef struct packed {
    logic valid;
  } res_hs_t;

endpackage

// ===== src/etfc_cfg.sv =====
module etfc_cfg import etfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level        <= RST_TRIGGER_LEVEL;
      cfg.rising_edge          <= 1'b1;
      cfg.auto_mode            <= 1'b1;
      cfg.auto_timeout_samples <= RST_AUTO_TIMEOUT;
      cfg.frame_length         <= RST_FRAME_LENGTH;
      cfg.dual_channel         <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIGGER_LEVEL: cfg.trigger_level        <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_RISING_EDGE:   cfg.rising_edge          <= cfg_wdata[0];
        REG_AUTO_MODE:     cfg.auto_mode            <= cfg_wdata[0];
        REG_AUTO_TIMEOUT:  cfg.auto_timeout_samples <= cfg_wdata[CNT_BITS-1:0];
        REG_FRAME_LENGTH:  cfg.frame_length         <= cfg_wdata[CNT_BITS-1:0];
        REG_DUAL_CHANNEL:  cfg.dual_channel         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/etfc_trig.sv =====
module etfc_trig import etfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_smp,
  output res_hs_t res_hs_o,
  input  logic    res_ready,
  output result_t res
);

  // Input register
  logic    smp_valid;
  sample_t smp;

  // Trigger state
  logic                   collecting;
  logic [SAMPLE_BITS-1:0] previous_raw;
  logic [CNT_BITS-1:0]    wait_count;
  logic [CNT_BITS-1:0]    capture_count;

  logic                edge_hit;
  logic                wait_upd;
  logic [CNT_BITS-1:0] wait_inc;
  logic [CNT_BITS-1:0] wait_eff;
  logic                fire;
  logic                active;
  logic [CNT_BITS-1:0] cap_base;
  logic [CNT_BITS-1:0] cap_inc;
  logic                last;
  logic                valid2;
  logic                advance;

  // Edge and auto trigger decision
  always_comb begin
    if (cfg.rising_edge) begin
      edge_hit = (previous_raw < cfg.trigger_level) && (smp.ch1_raw >= cfg.trigger_level);
    end else begin
      edge_hit = (previous_raw > cfg.trigger_level) && (smp.ch1_raw <= cfg.trigger_level);
    end
    wait_upd = !collecting && !edge_hit && cfg.auto_mode;
    wait_inc = (wait_count != CNT_MAX) ? wait_count + CNT_BITS'(1) : wait_count;
    wait_eff = wait_upd ? wait_inc : wait_count;
    fire     = !collecting && (edge_hit || (wait_upd && (wait_inc > cfg.auto_timeout_samples)));
    active   = collecting || fire;
    cap_base = fire ? '0 : capture_count;
    cap_inc  = cap_base + CNT_BITS'(1);
    // A wrapped count also closes the frame, so a zero length acts as one
    last     = active && ((cap_inc >= cfg.frame_length) || (cap_inc == '0));
    valid2   = cfg.dual_channel && smp.ch2_present;
  end

  // Build the result beat
  always_comb begin
    res.sample_index     = cap_base;
    res.out_ch1_raw      = smp.ch1_raw;
    res.out_ch1_filtered = smp.ch1_filtered;
    res.out_ch2_raw      = valid2 ? smp.ch2_raw : '0;
    res.out_ch2_filtered = valid2 ? smp.ch2_filtered : '0;
    res.out_ch2_valid    = valid2;
    res.frame_last       = last;
  end

  // Advance when the sample drops or the output slot is free
  assign advance        = smp_valid && (!active || res_ready);
  assign in_ready       = !smp_valid || advance;
  assign res_hs_o.valid = smp_valid && active;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      smp <= in_smp;
    end
  end

  // Update trigger state as each sample leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      previous_raw  <= '0;
      wait_count    <= '0;
      capture_count <= '0;
    end else if (advance) begin
      collecting <= active && !last;
      wait_count <= last ? '0 : wait_eff;
      if (active) begin
        capture_count <= cap_inc;
      end
      if (!last) begin
        previous_raw <= smp.ch1_raw;
      end
    end
  end

endmodule

// ===== src/etfc_out.sv =====
module etfc_out import etfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  res_hs_t                  res_hs_i,
  output logic                     res_ready,
  input  result_t                  res,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tuser,
  output logic                     m_tlast
);

  result_t res_q;

  // Slot frees as the waiting beat is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_hs_i.valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_hs_i.valid) begin
      res_q <= res;
    end
  end

  // Pack fields from the lowest bit up
  assign m_tdata = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0),
                    res_q.out_ch2_filtered, res_q.out_ch2_raw,
                    res_q.out_ch1_filtered, res_q.out_ch1_raw,
                    res_q.sample_index};
  assign m_tuser = res_q.out_ch2_valid;
  assign m_tlast = res_q.frame_last;

endmodule

// ===== src/edge_trigger_frame_capture_unit.sv =====
// Edge trigger with auto mode for a sampling front end. One sample beat is
// taken every cycle unless m_tready holds the output; a captured sample passes
// through an input register and an output register before it is offered on the
// master side. The trigger state is updated once per sample in a single pass,
// so the sustained rate is one sample per cycle, limited only by m_tready, which
// reaches s_tready combinationally. Write configuration only while no sample
// is in flight.
module edge_trigger_frame_capture_unit import etfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // ch1_raw, ch1_filtered, ch2_raw, ch2_filtered
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // ch2_present
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // sample_index, out_ch1_raw, out_ch1_filtered, out_ch2_raw, out_ch2_filtered, pad
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // out_ch2_valid
  output logic                     m_tuser,
  // frame_last
  output logic                     m_tlast
);

  cfg_t    cfg;
  sample_t in_smp;
  result_t res;
  res_hs_t res_hs;
  logic    res_ready;

  // Unpack the sample beat
  always_comb begin
    in_smp.ch1_raw      = s_tdata[SAMPLE_BITS-1:0];
    in_smp.ch1_filtered = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    in_smp.ch2_raw      = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    in_smp.ch2_filtered = s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
    in_smp.ch2_present  = s_tuser;
  end

  etfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  etfc_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_smp    (in_smp),
    .res_hs_o  (res_hs),
    .res_ready (res_ready),
    .res       (res)
  );

  etfc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_hs_i  (res_hs),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== src/etfc_checker.sv =====
module etfc_checker import etfc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tuser,
  input logic                     m_tlast
);

  logic                beat;
  logic [CNT_BITS-1:0] idx;
  logic [CNT_BITS-1:0] prev_idx;
  logic                prev_last;

  assign beat = m_tvalid && m_tready;
  assign idx  = m_tdata[CNT_BITS-1:0];

  // Track the index and frame end of the previous beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_idx  <= '0;
      prev_last <= 1'b1;
    end else if (beat) begin
      prev_idx  <= idx;
      prev_last <= m_tlast;
    end
  end

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result beat changed");

  // Channel two fields are zero when not valid
  a_ch2_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[OUT_FIELD_BITS-1:CNT_BITS+2*SAMPLE_BITS] == '0)
    else $error("channel two data without valid flag");

  // Frames start at zero and count up by one
  a_index: assert property (@(posedge clk) disable iff (rst)
    beat |-> (prev_last ? (idx == '0) : (idx == prev_idx + CNT_BITS'(1))))
    else $error("sample index out of sequence");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind edge_trigger_frame_capture_unit etfc_checker u_etfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
